// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the GPIO port RTL.
// Used by gpio_port_with_pin_interrupts; expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gpio port assertion failed");
`define GP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gpio port assertion failed");
`else
`define GP_ASSERT_IMP(lbl, ante, cons)
`define GP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/gpio_pi_pkg.sv -----
// Shared types and constants for the GPIO port with pin interrupts.
// No dependencies.
`timescale 1ns / 1ps
package gpio_pi_pkg;

    localparam int PIN_COUNT_DEF = 32;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // Data region offsets
    localparam logic [7:0] OFF_PDOR = 8'h00;
    localparam logic [7:0] OFF_PSOR = 8'h04;
    localparam logic [7:0] OFF_PCOR = 8'h08;
    localparam logic [7:0] OFF_PTOR = 8'h0C;
    localparam logic [7:0] OFF_PDIR = 8'h10;
    // Control region status offset
    localparam logic [7:0] OFF_ISR  = 8'hA0;

    localparam logic [3:0] MODE_LOW  = 4'h8;
    localparam logic [3:0] MODE_RISE = 4'h9;
    localparam logic [3:0] MODE_FALL = 4'hA;
    localparam logic [3:0] MODE_BOTH = 4'hB;
    localparam logic [3:0] MODE_HIGH = 4'hC;

    localparam int MODE_LSB = 16;
    localparam int FLAG_BIT = 24;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        region_select;
        logic [7:0]  byte_offset;
        logic [31:0] write_data;
        logic [31:0] pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
        logic        pending_valid;
        logic [4:0]  pending_pin;
    } t_out_item;

    // Decoded, accept-gated command broadcast to every cell
    typedef struct packed {
        logic       wr_pdor;
        logic       wr_psor;
        logic       wr_pcor;
        logic       wr_ptor;
        logic       wr_isr;
        logic       wr_pctl;
        logic       tick;
        logic [4:0] pin_sel;
        logic [3:0] mode_wr;
        logic       flag_clr;
    } t_cell_cmd;

endpackage

// ----- hw/rtl/gpio_pi_cell.sv -----
// One pin of the GPIO port: output bit, last sample, status flag, mode.
// Depends on gpio_pi_pkg.
`timescale 1ns / 1ps
module gpio_pi_cell #(
    parameter int P_INDEX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gpio_pi_pkg::t_cell_cmd i_cmd,
    input  logic                  i_wd_bit,
    input  logic                  i_lvl_bit,
    input  logic                  i_above,
    output logic                  o_above,
    output logic                  o_top,
    output logic                  o_out_bit,
    output logic                  o_sample_bit,
    output logic                  o_flag,
    output logic                  o_flag_next,
    output logic [3:0]            o_mode
);
    localparam logic [4:0] MY_PIN = 5'(P_INDEX);

    logic       r_out, n_out;
    logic       r_sample, n_sample;
    logic       r_flag, n_flag;
    logic [3:0] r_mode, n_mode;
    logic       w_hit;
    logic       w_sel;

    assign w_sel = i_cmd.wr_pctl && (i_cmd.pin_sel == MY_PIN);

    always_comb begin
        case (r_mode)
            gpio_pi_pkg::MODE_LOW:  w_hit = !i_lvl_bit;
            gpio_pi_pkg::MODE_HIGH: w_hit = i_lvl_bit;
            gpio_pi_pkg::MODE_RISE: w_hit = i_lvl_bit && !r_sample;
            gpio_pi_pkg::MODE_FALL: w_hit = !i_lvl_bit && r_sample;
            gpio_pi_pkg::MODE_BOTH: w_hit = i_lvl_bit != r_sample;
            default:                w_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_out    = r_out;
        n_sample = r_sample;
        n_flag   = r_flag;
        n_mode   = r_mode;
        if (i_cmd.wr_pdor) n_out = i_wd_bit;
        if (i_cmd.wr_psor) n_out = r_out | i_wd_bit;
        if (i_cmd.wr_pcor) n_out = r_out & ~i_wd_bit;
        if (i_cmd.wr_ptor) n_out = r_out ^ i_wd_bit;
        if (i_cmd.tick) begin
            n_sample = i_lvl_bit;
            n_flag   = r_flag | w_hit;
        end
        if (i_cmd.wr_isr && i_wd_bit) n_flag = 1'b0;
        if (w_sel) begin
            n_mode = i_cmd.mode_wr;
            if (i_cmd.flag_clr) n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out    <= 1'b0;
            r_sample <= 1'b0;
            r_flag   <= 1'b0;
            r_mode   <= 4'h0;
        end else begin
            r_out    <= n_out;
            r_sample <= n_sample;
            r_flag   <= n_flag;
            r_mode   <= n_mode;
        end
    end

    // Pass "some higher pin is pending" down the row
    assign o_above      = i_above | n_flag;
    assign o_top        = n_flag & ~i_above;
    assign o_out_bit    = r_out;
    assign o_sample_bit = r_sample;
    assign o_flag       = r_flag;
    assign o_flag_next  = n_flag;
    assign o_mode       = r_mode;
endmodule

// ----- hw/rtl/gpio_port_with_pin_interrupts.sv -----
// GPIO port with per-pin edge/level interrupts: one cell per pin in a row.
// Each accepted item's result is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle while the output is not stalled; every item updates all cells in parallel and
// the highest-pending search ripples through the row in the same cycle.
// Reset: synchronous, active low; clears output word, sample, status and modes.
// Depends on gpio_pi_pkg, gpio_pi_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpio_port_with_pin_interrupts #(
    parameter int PIN_COUNT = gpio_pi_pkg::PIN_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  gpio_pi_pkg::t_in_item  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output gpio_pi_pkg::t_out_item o_out
);
    localparam logic [6:0] PC7 = 7'(PIN_COUNT);

    logic                   w_accept;
    logic                   w_rd, w_wr, w_tick;
    logic                   w_aligned;
    logic                   w_pctl_hit;
    gpio_pi_pkg::t_cell_cmd w_cmd;

    logic [PIN_COUNT-1:0]   w_out_word, w_sample, w_flag, w_flag_next, w_top;
    logic [PIN_COUNT:0]     w_above;
    logic [3:0]             w_mode [PIN_COUNT];

    logic [31:0]            w_rdata;
    logic [3:0]             w_sel_mode;
    logic                   w_sel_flag;
    logic [4:0]             w_pend_pin;

    logic                   r_out_valid, n_out_valid;
    gpio_pi_pkg::t_out_item r_out;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_rd      = w_accept && (i_in.opcode == gpio_pi_pkg::OP_READ);
    assign w_wr      = w_accept && (i_in.opcode == gpio_pi_pkg::OP_WRITE);
    assign w_tick    = w_accept && (i_in.opcode == gpio_pi_pkg::OP_TICK);
    assign w_aligned = (i_in.byte_offset[1:0] == 2'b00);
    assign w_pctl_hit = w_aligned && !i_in.region_select
                        && ({1'b0, i_in.byte_offset[7:2]} < PC7);

    always_comb begin
        w_cmd.wr_pdor  = w_wr && i_in.region_select && (i_in.byte_offset == gpio_pi_pkg::OFF_PDOR);
        w_cmd.wr_psor  = w_wr && i_in.region_select && (i_in.byte_offset == gpio_pi_pkg::OFF_PSOR);
        w_cmd.wr_pcor  = w_wr && i_in.region_select && (i_in.byte_offset == gpio_pi_pkg::OFF_PCOR);
        w_cmd.wr_ptor  = w_wr && i_in.region_select && (i_in.byte_offset == gpio_pi_pkg::OFF_PTOR);
        w_cmd.wr_isr   = w_wr && !i_in.region_select && (i_in.byte_offset == gpio_pi_pkg::OFF_ISR);
        w_cmd.wr_pctl  = w_wr && w_pctl_hit;
        w_cmd.tick     = w_tick;
        w_cmd.pin_sel  = i_in.byte_offset[6:2];
        w_cmd.mode_wr  = i_in.write_data[gpio_pi_pkg::MODE_LSB +: 4];
        w_cmd.flag_clr = i_in.write_data[gpio_pi_pkg::FLAG_BIT];
    end

    assign w_above[PIN_COUNT] = 1'b0;

    for (genvar p = 0; p < PIN_COUNT; p++) begin : g_cell
        gpio_pi_cell #(
            .P_INDEX (p)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_wd_bit     (i_in.write_data[p]),
            .i_lvl_bit    (i_in.pin_levels[p]),
            .i_above      (w_above[p+1]),
            .o_above      (w_above[p]),
            .o_top        (w_top[p]),
            .o_out_bit    (w_out_word[p]),
            .o_sample_bit (w_sample[p]),
            .o_flag       (w_flag[p]),
            .o_flag_next  (w_flag_next[p]),
            .o_mode       (w_mode[p])
        );
    end

    // Select the addressed pin's mode and flag, and encode the top pending pin
    always_comb begin
        w_sel_mode = 4'h0;
        w_sel_flag = 1'b0;
        w_pend_pin = 5'd0;
        for (int p = 0; p < PIN_COUNT; p++) begin
            if (w_cmd.pin_sel == 5'(p)) begin
                w_sel_mode = w_sel_mode | w_mode[p];
                w_sel_flag = w_sel_flag | w_flag[p];
            end
            if (w_top[p]) w_pend_pin = w_pend_pin | 5'(p);
        end
    end

    always_comb begin
        w_rdata = 32'h0;
        if (w_rd && w_aligned) begin
            if (i_in.region_select) begin
                if (i_in.byte_offset == gpio_pi_pkg::OFF_PDOR) w_rdata = 32'(w_out_word);
                if (i_in.byte_offset == gpio_pi_pkg::OFF_PDIR) w_rdata = 32'(w_sample);
            end else if (i_in.byte_offset == gpio_pi_pkg::OFF_ISR) begin
                w_rdata = 32'(w_flag);
            end else if (w_pctl_hit) begin
                w_rdata[gpio_pi_pkg::MODE_LSB +: 4] = w_sel_mode;
                w_rdata[gpio_pi_pkg::FLAG_BIT]      = w_sel_flag;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result while stalled; load on every accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.read_data     <= w_rdata;
            r_out.irq_line      <= |w_flag_next;
            r_out.pending_valid <= w_above[0];
            r_out.pending_pin   <= w_pend_pin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `GP_ASSERT_IMP(a_stall_needs_result, o_in_stall, o_out_valid)
    `GP_ASSERT_NEXT(a_accept_gives_result, w_accept, o_out_valid)
    `GP_ASSERT_IMP(a_irq_matches_pending, o_out_valid, o_out.irq_line == o_out.pending_valid)
    `GP_ASSERT_IMP(a_no_pending_pin_zero, o_out_valid && !o_out.pending_valid,
                   o_out.pending_pin == 5'd0)
endmodule
